// File: rtl/core/tsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared widths, codes and stream layout for the trade side classifier.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int PRICE_WIDTH = 32;
  localparam int TIME_WIDTH  = 40;
  localparam int SIZE_WIDTH  = 32;
  localparam int SEQ_WIDTH   = 32;
  localparam int CFG_WIDTH   = 16;
  localparam int CODE_WIDTH  = 2;
  localparam int CFG_INDEX_WIDTH = 4;

  localparam int IN_BITS   = TIME_WIDTH + 3 * PRICE_WIDTH + SIZE_WIDTH;
  localparam int IN_BYTES  = (IN_BITS + 7) / 8;
  localparam int IN_TDATA_WIDTH = IN_BYTES * 8;
  localparam int OUT_BITS  = SEQ_WIDTH + 2 * CODE_WIDTH;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int OUT_TDATA_WIDTH = OUT_BYTES * 8;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_QUOTE_AGE = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRICE_MARGIN  = CFG_INDEX_WIDTH'(1);

  localparam logic [CFG_WIDTH-1:0] MAX_QUOTE_AGE_RESET = CFG_WIDTH'(2);
  localparam logic [CFG_WIDTH-1:0] PRICE_MARGIN_RESET  = CFG_WIDTH'(0);

  localparam logic OP_QUOTE = 1'b0;
  localparam logic OP_TRADE = 1'b1;

  localparam logic [CODE_WIDTH-1:0] SIDE_UNKNOWN = 2'd0;
  localparam logic [CODE_WIDTH-1:0] SIDE_BUY     = 2'd1;
  localparam logic [CODE_WIDTH-1:0] SIDE_SELL    = 2'd2;

  localparam logic [CODE_WIDTH-1:0] METHOD_NONE  = 2'd0;
  localparam logic [CODE_WIDTH-1:0] METHOD_QUOTE = 2'd1;
  localparam logic [CODE_WIDTH-1:0] METHOD_TICK  = 2'd2;

  typedef struct packed {
    logic [SIZE_WIDTH-1:0]  trade_size;
    logic [PRICE_WIDTH-1:0] trade_price;
    logic [PRICE_WIDTH-1:0] ask_px;
    logic [PRICE_WIDTH-1:0] bid_px;
    logic [TIME_WIDTH-1:0]  timestamp_s;
  } event_t;

endpackage

// File: rtl/core/trade_side_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trade_side_classifier
// Quote-test and tick-rule buy/sell classification of trade prints.
// ----------------------------------------------------------------------------
// Input stream: one market event per transfer. s_tuser selects quote update
// or trade print; s_tdata carries time, bid, ask, trade price and size.
// Output stream: one result per event. m_tuser is the accepted flag;
// m_tdata carries sequence number, side and method (all zero on reject).
// Config channel: cfg_index selects max_quote_age (0) or price_margin (1);
// other indexes are ignored. cfg_ready is always high. Write only while idle.
// Path: each event passes the input register, then the result register.
// Throughput: one event per cycle while the output is not stalled, set by
// the single compare stage that reads and updates the quote/trade state.
// Stall: while m_tready is low the result register holds, the input register
// still takes one more event, then s_tready drops until the output drains.
// Reset (rst, synchronous): both stages empty, stored quote and prior trade
// cleared, direction unknown, sequence restarts at zero, registers at their
// defaults (max_quote_age 2, price_margin 0).
// ----------------------------------------------------------------------------
module trade_side_classifier (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tsc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [tsc_pkg::CFG_WIDTH-1:0]         cfg_data,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // timestamp_s, bid_px, ask_px, trade_price, trade_size
  input  logic [tsc_pkg::IN_TDATA_WIDTH-1:0]    s_tdata,
  // operation
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // sequence_number, side, method, zero fill
  output logic [tsc_pkg::OUT_TDATA_WIDTH-1:0]   m_tdata,
  // accepted
  output logic                                  m_tuser
);
  import tsc_pkg::*;

  logic [CFG_WIDTH-1:0]   max_quote_age;
  logic [CFG_WIDTH-1:0]   price_margin;

  logic                   quote_valid;
  logic [TIME_WIDTH-1:0]  quote_time;
  logic [PRICE_WIDTH-1:0] quote_bid;
  logic [PRICE_WIDTH-1:0] quote_ask;
  logic                   prior_trade_valid;
  logic [PRICE_WIDTH-1:0] prior_trade_price;
  logic [CODE_WIDTH-1:0]  last_direction;
  logic [SEQ_WIDTH-1:0]   next_sequence;

  logic                   in_valid;
  logic                   in_op;
  event_t                 in_event;

  logic                   out_valid;
  logic                   out_accepted;
  logic [SEQ_WIDTH-1:0]   out_sequence;
  logic [CODE_WIDTH-1:0]  out_side;
  logic [CODE_WIDTH-1:0]  out_method;

  logic                   advance;
  logic                   take;

  logic                   accept_next;
  logic [CODE_WIDTH-1:0]  side_next;
  logic [CODE_WIDTH-1:0]  method_next;

  logic                   quote_ok;
  logic                   trade_ok;
  logic                   fresh;
  logic [TIME_WIDTH:0]    age;
  logic [PRICE_WIDTH:0]   price_up;
  logic [PRICE_WIDTH:0]   bid_up;
  logic [PRICE_WIDTH:0]   prior_up;
  logic                   quote_buy;
  logic                   quote_sell;
  logic                   tick_up;
  logic                   tick_down;
  logic [CODE_WIDTH-1:0]  tick_side;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign take      = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_accepted;
  assign m_tdata  = OUT_TDATA_WIDTH'({out_method, out_side, out_sequence});

  always_comb begin
    quote_ok = (in_event.bid_px != '0) && (in_event.ask_px >= in_event.bid_px);
    trade_ok = (in_event.trade_price != '0) && (in_event.trade_size != '0);

    age   = {1'b0, in_event.timestamp_s} - {1'b0, quote_time};
    fresh = quote_valid && !age[TIME_WIDTH]
            && (age <= (TIME_WIDTH + 1)'(max_quote_age));

    price_up = {1'b0, in_event.trade_price} + (PRICE_WIDTH + 1)'(price_margin);
    bid_up   = {1'b0, quote_bid} + (PRICE_WIDTH + 1)'(price_margin);
    prior_up = {1'b0, prior_trade_price} + (PRICE_WIDTH + 1)'(price_margin);

    quote_buy  = fresh && (price_up >= {1'b0, quote_ask});
    quote_sell = fresh && ({1'b0, in_event.trade_price} <= bid_up);
    tick_up    = {1'b0, in_event.trade_price} > prior_up;
    tick_down  = price_up < {1'b0, prior_trade_price};

    priority if (tick_up) begin
      tick_side = SIDE_BUY;
    end else if (tick_down) begin
      tick_side = SIDE_SELL;
    end else begin
      tick_side = last_direction;
    end

    side_next   = SIDE_UNKNOWN;
    method_next = METHOD_NONE;
    if (in_op == OP_TRADE) begin
      accept_next = trade_ok;
      priority if (quote_buy) begin
        side_next   = SIDE_BUY;
        method_next = METHOD_QUOTE;
      end else if (quote_sell) begin
        side_next   = SIDE_SELL;
        method_next = METHOD_QUOTE;
      end else if (prior_trade_valid) begin
        side_next   = tick_side;
        method_next = (tick_side != SIDE_UNKNOWN) ? METHOD_TICK : METHOD_NONE;
      end
      if (!trade_ok) begin
        side_next   = SIDE_UNKNOWN;
        method_next = METHOD_NONE;
      end
    end else begin
      accept_next = quote_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_quote_age <= MAX_QUOTE_AGE_RESET;
      price_margin  <= PRICE_MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MAX_QUOTE_AGE) begin
        max_quote_age <= cfg_data;
      end else if (cfg_index == REG_PRICE_MARGIN) begin
        price_margin <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_op    <= s_tuser;
      in_event <= s_tdata[IN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_accepted <= accept_next;
      out_sequence <= accept_next ? next_sequence : '0;
      out_side     <= side_next;
      out_method   <= method_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_valid       <= 1'b0;
      quote_time        <= '0;
      quote_bid         <= '0;
      quote_ask         <= '0;
      prior_trade_valid <= 1'b0;
      prior_trade_price <= '0;
      last_direction    <= SIDE_UNKNOWN;
      next_sequence     <= '0;
    end else if (advance && accept_next) begin
      next_sequence <= next_sequence + SEQ_WIDTH'(1);
      if (in_op == OP_QUOTE) begin
        quote_valid <= 1'b1;
        quote_time  <= in_event.timestamp_s;
        quote_bid   <= in_event.bid_px;
        quote_ask   <= in_event.ask_px;
      end else begin
        prior_trade_valid <= 1'b1;
        prior_trade_price <= in_event.trade_price;
        if (side_next != SIDE_UNKNOWN) begin
          last_direction <= side_next;
        end
      end
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the trade side classifier. A queue of market events
// feeds a stream driver with random gaps, a monitor predicts the outcome of
// every event transfer and checks each result transfer in order, and the
// result side stalls at random. The run steps through several register
// settings, the extremes among them, between directed and random events.
// ----------------------------------------------------------------------------
module testbench;
  import tsc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int SIDE_LSB = SEQ_WIDTH;
  localparam int METHOD_LSB = SEQ_WIDTH + CODE_WIDTH;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LOW = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_TOP = CFG_INDEX_WIDTH'(15);
  localparam logic [TIME_WIDTH-1:0] TIME_TOP = '1;
  localparam logic [PRICE_WIDTH-1:0] PRICE_TOP = '1;
  localparam logic [SIZE_WIDTH-1:0] SIZE_TOP = '1;

  typedef struct packed {
    logic   op;
    event_t ev;
  } market_item_t;

  typedef struct packed {
    logic                  accepted;
    logic [SEQ_WIDTH-1:0]  seq;
    logic [CODE_WIDTH-1:0] side;
    logic [CODE_WIDTH-1:0] method;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_WIDTH-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] m_tdata;
  logic m_tuser;

  trade_side_classifier uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  market_item_t pending_events[$];
  outcome_t expected_outcomes[$];
  market_item_t current = '0;
  int cycle_count = 0;
  int error_count = 0;
  int issued_count = 0;
  int accepted_count = 0;
  bit event_taken = 1'b0;
  bit result_taken = 1'b0;
  bit holding = 1'b0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;

  // classifier state as predicted
  logic [63:0] age_limit = 64'(MAX_QUOTE_AGE_RESET);
  logic [63:0] tick_margin = 64'(PRICE_MARGIN_RESET);
  logic book_valid = 1'b0;
  logic [63:0] book_time = '0;
  logic [63:0] book_bid = '0;
  logic [63:0] book_ask = '0;
  logic last_trade_valid = 1'b0;
  logic [63:0] last_trade_price = '0;
  logic [CODE_WIDTH-1:0] trend = SIDE_UNKNOWN;
  logic [SEQ_WIDTH-1:0] seq_next = '0;

  task automatic enqueue_event(input market_item_t it);
    pending_events.insert(pending_events.size(), it);
  endtask

  function automatic void apply_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                    input logic [CFG_WIDTH-1:0] val);
    if (idx == REG_MAX_QUOTE_AGE) age_limit = 64'(val);
    else if (idx == REG_PRICE_MARGIN) tick_margin = 64'(val);
  endfunction

  function automatic outcome_t classify_event(input logic op, input event_t ev);
    outcome_t r;
    logic fresh;
    logic [63:0] t;
    logic [63:0] px;
    logic [CODE_WIDTH-1:0] dir;
    logic [CODE_WIDTH-1:0] how;
    r = '0;
    t = 64'(ev.timestamp_s);
    px = 64'(ev.trade_price);
    dir = SIDE_UNKNOWN;
    how = METHOD_NONE;
    if (op == OP_QUOTE) begin
      if (ev.bid_px == '0 || ev.ask_px < ev.bid_px) return r;
      book_valid = 1'b1;
      book_time = t;
      book_bid = 64'(ev.bid_px);
      book_ask = 64'(ev.ask_px);
    end else begin
      if (ev.trade_price == '0 || ev.trade_size == '0) return r;
      fresh = book_valid && t >= book_time && (t - book_time) <= age_limit;
      if (fresh && px + tick_margin >= book_ask) begin
        dir = SIDE_BUY;
        how = METHOD_QUOTE;
      end else if (fresh && px <= book_bid + tick_margin) begin
        dir = SIDE_SELL;
        how = METHOD_QUOTE;
      end else if (last_trade_valid) begin
        if (px > last_trade_price + tick_margin) dir = SIDE_BUY;
        else if (px + tick_margin < last_trade_price) dir = SIDE_SELL;
        else dir = trend;
        if (dir != SIDE_UNKNOWN) how = METHOD_TICK;
      end
      last_trade_valid = 1'b1;
      last_trade_price = px;
      if (dir != SIDE_UNKNOWN) trend = dir;
    end
    r.accepted = 1'b1;
    r.seq = seq_next;
    r.side = dir;
    r.method = how;
    seq_next = seq_next + SEQ_WIDTH'(1);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 50) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_result();
    outcome_t want;
    logic [SEQ_WIDTH-1:0] got_seq;
    logic [CODE_WIDTH-1:0] got_side;
    logic [CODE_WIDTH-1:0] got_method;
    if (expected_outcomes.size() == 0) begin
      report_mismatch("result transfer with nothing expected");
      return;
    end
    want = expected_outcomes[0];
    expected_outcomes.delete(0);
    got_seq = m_tdata[SEQ_WIDTH-1:0];
    got_side = m_tdata[SIDE_LSB +: CODE_WIDTH];
    got_method = m_tdata[METHOD_LSB +: CODE_WIDTH];
    if (m_tuser !== want.accepted)
      report_mismatch($sformatf("accepted %b, want %b", m_tuser, want.accepted));
    if (got_seq !== want.seq)
      report_mismatch($sformatf("sequence %0d, want %0d", got_seq, want.seq));
    if (got_side !== want.side)
      report_mismatch($sformatf("side %0d, want %0d", got_side, want.side));
    if (got_method !== want.method)
      report_mismatch($sformatf("method %0d, want %0d", got_method, want.method));
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (!rst) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) begin
        expected_outcomes.insert(expected_outcomes.size(),
                                 classify_event(s_tuser, event_t'(s_tdata)));
        accepted_count++;
        event_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        check_result();
        result_taken = 1'b1;
      end
    end
  end

  // event stream driver
  always @(negedge clk) begin
    if (!rst) begin
      if (event_taken) begin
        event_taken = 1'b0;
        holding = 1'b0;
        send_gap = send_steady ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_events.size() > 0) begin
          current = pending_events[0];
          pending_events.delete(0);
          holding = 1'b1;
          issued_count++;
        end
      end
      s_tvalid <= holding;
      s_tuser <= current.op;
      s_tdata <= current.ev;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      if (result_taken) begin
        result_taken = 1'b0;
        recv_stall = recv_steady ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic market_item_t make_quote(input logic [TIME_WIDTH-1:0] t,
                                              input logic [PRICE_WIDTH-1:0] bid,
                                              input logic [PRICE_WIDTH-1:0] ask);
    market_item_t it;
    it = '0;
    it.op = OP_QUOTE;
    it.ev.timestamp_s = t;
    it.ev.bid_px = bid;
    it.ev.ask_px = ask;
    return it;
  endfunction

  function automatic market_item_t make_trade(input logic [TIME_WIDTH-1:0] t,
                                              input logic [PRICE_WIDTH-1:0] px,
                                              input logic [SIZE_WIDTH-1:0] qty);
    market_item_t it;
    it = '0;
    it.op = OP_TRADE;
    it.ev.timestamp_s = t;
    it.ev.trade_price = px;
    it.ev.trade_size = qty;
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [CFG_WIDTH-1:0] age,
                            input logic [CFG_WIDTH-1:0] margin);
    write_reg(REG_MAX_QUOTE_AGE, age);
    write_reg(REG_PRICE_MARGIN, margin);
    write_reg($urandom_range(0, 1) ? REG_SPARE_LOW : REG_SPARE_TOP, CFG_WIDTH'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_events.size() != 0 || issued_count != accepted_count
           || expected_outcomes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_random_events(input int count, input logic [PRICE_WIDTH-1:0] level);
    logic [TIME_WIDTH-1:0] now;
    logic [PRICE_WIDTH-1:0] mid;
    logic [PRICE_WIDTH-1:0] half;
    logic [PRICE_WIDTH-1:0] bid;
    market_item_t it;
    int roll;
    now = {8'($urandom_range(0, 200)), $urandom};
    mid = level;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      now = now + $urandom_range(0, 3);
      mid = mid + $urandom_range(0, 8) - 4;
      half = $urandom_range(0, 6);
      if (roll < 10) begin
        it.op = 1'($urandom_range(0, 1));
        it.ev.timestamp_s = {8'($urandom), $urandom};
        it.ev.bid_px = $urandom;
        it.ev.ask_px = $urandom;
        it.ev.trade_price = $urandom;
        it.ev.trade_size = $urandom;
      end else if (roll < 20) begin
        case ($urandom_range(0, 3))
          0: it = make_quote(now, '0, mid + half);
          1: begin
            bid = mid | 32'd2;
            it = make_quote(now, bid, bid - $urandom_range(1, 2));
          end
          2: it = make_trade(now, '0, $urandom_range(1, 1000));
          default: it = make_trade(now, mid, '0);
        endcase
      end else if (roll < 28) begin
        // trade stamped before the running time, at times before the stored quote
        it = make_trade(now - $urandom_range(1, 3), mid + $urandom_range(0, 8) - 4,
                        $urandom_range(1, 5000));
      end else if (roll < 55) begin
        it = make_quote(now, mid - half, mid + half);
      end else begin
        it = make_trade(now, mid + $urandom_range(0, 2 * half + 8) - half - 4, $urandom);
      end
      enqueue_event(it);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: quote age 2, no margin
    enqueue_event(make_trade(0, 100, 1));
    enqueue_event(make_trade(1, 100, 5));
    enqueue_event(make_quote(2, 0, 50));
    enqueue_event(make_quote(2, 60, 50));
    enqueue_event(make_quote(10, 1000, 1000));
    enqueue_event(make_trade(12, 0, 7));
    enqueue_event(make_trade(12, 500, 0));
    enqueue_event(make_trade(12, 1000, 3));
    enqueue_event(make_quote(20, 900, 1100));
    enqueue_event(make_trade(23, 1000, 4));
    enqueue_event(make_trade(19, 900, 2));
    enqueue_event(make_trade(20, 900, 2));
    enqueue_event(make_trade(21, 1000, 2));
    enqueue_event(make_quote(TIME_TOP, PRICE_TOP, PRICE_TOP));
    enqueue_event(make_trade(TIME_TOP, PRICE_TOP, SIZE_TOP));
    enqueue_event(make_quote(0, 1, PRICE_TOP));
    enqueue_event(make_trade(0, 1, 1));
    drain();

    // widest age and margin: ask below the margin must not wrap
    set_config('1, '1);
    enqueue_event(make_quote(100, 1, 10));
    enqueue_event(make_trade(100 + 65535, 1, 9));
    enqueue_event(make_trade(100 + 65536, 1, 9));
    enqueue_event(make_trade(200000, 100000, 1));
    enqueue_event(make_trade(200001, 30000, 1));
    drain();

    // zero age, bid plus margin past the top of the range
    set_config(0, 16'h0020);
    enqueue_event(make_quote(500, 32'hFFFF_FFF0, PRICE_TOP));
    enqueue_event(make_trade(500, 32'h0000_1000, 1));
    enqueue_event(make_trade(501, 32'h0000_1000, 1));
    drain();

    set_config(0, 0);
    add_random_events(120, 32'd1000000);
    drain();
    set_config('1, '1);
    add_random_events(120, 32'd5000000);
    drain();
    set_config(2, 1);
    add_random_events(120, 32'hFFFF_FF00);
    drain();
    set_config(CFG_WIDTH'($urandom_range(0, 4)), CFG_WIDTH'($urandom_range(0, 6)));
    add_random_events(120, 32'd20);
    drain();
    set_config(3, 2);
    add_random_events(120, $urandom);
    drain();

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
